// File: src/ctup_pkg.sv
// Shared types and constants for the counting trie unique prefix block.
`timescale 1ns / 1ps

package ctup_pkg;

    localparam int LETTER_W = 5;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // func codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_UNIQUE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WHOLE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic                func;
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } in_t;

    typedef struct packed {
        logic [LEN_W-1:0]    prefix_length;
        logic [STATUS_W-1:0] status;
    } out_t;

endpackage

// File: src/counting_trie_unique_prefix.sv
// Top level: counting trie that inserts keys and answers shortest unique prefix queries.
// Each input word is one letter: S_IDLE goes to S_DONE when no lookup is needed, via
// S_CHILD when the child slot is empty (new node or miss), via S_CHILD and S_COUNT when
// an existing child's count is read. S_DONE registers the result once the output is free.
// Reset (aresetn low, synchronous) clears control state, then a sweep zeroes the child
// table one entry a cycle: NODE_COUNT*ALPHABET_SIZE slots (26624 by default), s_ready low.
`timescale 1ns / 1ps

module counting_trie_unique_prefix
    import ctup_pkg::*;
#(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_WORD_LEN  = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int FREE_W      = $clog2(NODE_COUNT + 1);
    localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int CADDR_W     = $clog2(CHILD_DEPTH);
    localparam int DEPTH_W     = $clog2(MAX_WORD_LEN + 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a letter
    localparam logic [1:0] S_CHILD = 2'd1;  // child pointer read data is valid
    localparam logic [1:0] S_COUNT = 2'd2;  // pass count read data is valid
    localparam logic [1:0] S_DONE  = 2'd3;  // post result on the last letter

    logic [1:0]          state_reg, state_next;
    logic                func_reg, func_next;
    logic                last_reg, last_next;
    logic [CADDR_W-1:0]  slot_reg, slot_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [DEPTH_W-1:0]  found_len_reg, found_len_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] fault_reg, fault_next;
    logic                clear_reg, clear_next;
    logic [CADDR_W-1:0]  clear_addr_reg, clear_addr_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;

    // Memory ports
    logic [CADDR_W-1:0] slot_addr;
    logic               child_we;
    logic [CADDR_W-1:0] child_waddr;
    logic [NODE_W-1:0]  child_wdata;
    logic [NODE_W-1:0]  child_rdata;
    logic               count_we;
    logic [NODE_W-1:0]  count_waddr;
    logic [COUNT_W-1:0] count_wdata;
    logic [NODE_W-1:0]  count_raddr;
    logic [COUNT_W-1:0] count_rdata;

    logic bad_letter;
    logic accept;
    logic out_free;
    out_t result;

    // Child slot of the current cursor for the incoming letter.
    assign slot_addr = CADDR_W'(cursor_reg) * CADDR_W'(ALPHABET_SIZE)
                     + CADDR_W'(s_data.letter);

    assign bad_letter = (32'(s_data.letter) >= 32'(ALPHABET_SIZE));
    assign s_ready    = (state_reg == S_IDLE) && !clear_reg;
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;

    // Result from the per-key state as it stands after the last letter.
    always_comb begin
        result = '0;
        if (fault_reg != ST_UNIQUE) begin
            result.status = fault_reg;
        end else if (func_reg == FUNC_INSERT) begin
            result.status = ST_UNIQUE;
        end else if (found_reg) begin
            result.status        = ST_UNIQUE;
            result.prefix_length = LEN_W'(found_len_reg);
        end else begin
            result.status        = ST_WHOLE;
            result.prefix_length = LEN_W'(depth_reg);
        end
    end

    // The sequencer runs one letter at a time, so a count write always lands
    // before the next letter's read of the same node: no forwarding needed.
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        last_next       = last_reg;
        slot_next       = slot_reg;
        cursor_next     = cursor_reg;
        free_next       = free_reg;
        depth_next      = depth_reg;
        found_len_next  = found_len_reg;
        found_next      = found_reg;
        fault_next      = fault_reg;
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        child_we    = 1'b0;
        child_waddr = slot_reg;
        child_wdata = free_reg[NODE_W-1:0];
        count_we    = 1'b0;
        count_waddr = cursor_reg;
        count_wdata = count_rdata + COUNT_W'(1);
        count_raddr = child_rdata;

        // Post-reset sweep of the child table
        if (clear_reg) begin
            child_we        = 1'b1;
            child_waddr     = clear_addr_reg;
            child_wdata     = '0;
            clear_addr_next = clear_addr_reg + CADDR_W'(1);
            if (clear_addr_reg == CADDR_W'(CHILD_DEPTH - 1)) begin
                clear_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    func_next = s_data.func;
                    last_next = s_data.last_letter;
                    slot_next = slot_addr;
                    if (depth_reg != DEPTH_W'(MAX_WORD_LEN)) begin
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                    if (fault_reg != ST_UNIQUE) begin
                        state_next = S_DONE;
                    end else if (bad_letter) begin
                        fault_next = ST_ABSENT;
                        state_next = S_DONE;
                    end else if (s_data.func == FUNC_QUERY && found_reg) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_CHILD;
                    end
                end
            end
            S_CHILD: begin
                state_next = S_DONE;
                if (child_rdata == '0) begin
                    if (func_reg == FUNC_QUERY) begin
                        fault_next = ST_ABSENT;
                    end else if (free_reg == FREE_W'(NODE_COUNT)) begin
                        fault_next = ST_FULL;
                    end else begin
                        // New node: link it and start its count at one.
                        child_we    = 1'b1;
                        child_waddr = slot_reg;
                        child_wdata = free_reg[NODE_W-1:0];
                        count_we    = 1'b1;
                        count_waddr = free_reg[NODE_W-1:0];
                        count_wdata = COUNT_W'(1);
                        cursor_next = free_reg[NODE_W-1:0];
                        free_next   = free_reg + FREE_W'(1);
                    end
                end else begin
                    cursor_next = child_rdata;
                    state_next  = S_COUNT;
                end
            end
            S_COUNT: begin
                state_next = S_DONE;
                if (func_reg == FUNC_INSERT) begin
                    count_we    = (count_rdata != COUNT_MAX);
                    count_waddr = cursor_reg;
                    count_wdata = count_rdata + COUNT_W'(1);
                end else if (count_rdata == COUNT_W'(1)) begin
                    found_next     = 1'b1;
                    found_len_next = depth_reg;
                end
            end
            S_DONE: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = result;
                    cursor_next    = '0;
                    depth_next     = '0;
                    found_len_next = '0;
                    found_next     = 1'b0;
                    fault_next     = ST_UNIQUE;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            func_reg       <= FUNC_INSERT;
            last_reg       <= 1'b0;
            cursor_reg     <= '0;
            free_reg       <= FREE_W'(1);
            depth_reg      <= '0;
            found_len_reg  <= '0;
            found_reg      <= 1'b0;
            fault_reg      <= ST_UNIQUE;
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            last_reg       <= last_next;
            cursor_reg     <= cursor_next;
            free_reg       <= free_next;
            depth_reg      <= depth_next;
            found_len_reg  <= found_len_next;
            found_reg      <= found_next;
            fault_reg      <= fault_next;
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Child pointers, NODE_COUNT rows of ALPHABET_SIZE slots; zero means no child.
    ctup_ram #(
        .WIDTH (NODE_W),
        .DEPTH (CHILD_DEPTH)
    ) u_child_ram (
        .aclk    (aclk),
        .wr_en   (child_we),
        .wr_addr (child_waddr),
        .wr_data (child_wdata),
        .rd_addr (slot_addr),
        .rd_data (child_rdata)
    );

    // Pass counts; a node's entry is first written when it is allocated.
    ctup_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NODE_COUNT)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (count_we),
        .wr_addr (count_waddr),
        .wr_data (count_wdata),
        .rd_addr (count_raddr),
        .rd_data (count_rdata)
    );

endmodule

// File: src/ctup_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps

module ctup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/ctup_checker.sv
// Port-level checker for the counting trie unique prefix block, with its bind.
`timescale 1ns / 1ps

module ctup_checker
    import ctup_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    // A waiting input word holds until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word dropped or changed while waiting");

    // One letter at a time: no accept in the cycle after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // Faults never report a prefix length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_ABSENT || m_data.status == ST_FULL)
        |-> m_data.prefix_length == '0)
        else $error("fault status with nonzero prefix length");

    // Out of reset: no result pending and input held off for the table sweep.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block not quiet after reset");

endmodule

bind counting_trie_unique_prefix ctup_checker u_ctup_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: bench/tb_counting_trie_unique_prefix.sv
// Testbench for the counting trie unique prefix block: directed words, random words, checks.
`timescale 1ns / 1ps

module tb_counting_trie_unique_prefix;
    import ctup_pkg::*;

    // Block configuration, kept equal to the instance below.
    localparam int NODES   = 1024;
    localparam int ALPHA   = 26;
    localparam int MAX_LEN = 32;

    localparam int RANDOM_LETTERS = 180;   // letters that act on the trie, over three phases
    localparam int SETTLE_CYCLES  = 12;    // idle margin once every answer is back
    localparam int WORD_SLOTS     = 64;    // longest word buffer
    localparam int LEX_SLOTS      = 48;    // remembered inserted words for reuse
    localparam int LEX_LETTERS    = 16;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    counting_trie_unique_prefix #(
        .NODE_COUNT    (NODES),
        .ALPHABET_SIZE (ALPHA),
        .MAX_WORD_LEN  (MAX_LEN)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Trie shadow: node table, pass counts and the per-word walk state.
    // ------------------------------------------------------------------
    logic [9:0]         kid_ptr [NODES*ALPHA];  // 0 = no child
    logic [COUNT_W-1:0] pass_cnt [NODES];
    int                 next_free;
    int                 walk_node;
    int                 walk_depth;
    int                 hit_depth;
    logic               hit_seen;
    logic [STATUS_W-1:0] word_fault;

    out_t pending_answers [$];   // expected word results, oldest first

    int mismatch_count = 0;
    int letters_used   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;      // cycles the receiver still refuses results

    // Word being sent: letter codes and per-letter selector.
    logic [4:0] word_buf [WORD_SLOTS];
    logic       func_buf [WORD_SLOTS];
    int         word_len;

    // Inserted words kept around so queries and re-inserts hit real paths.
    logic [4:0] lex_word [LEX_SLOTS][LEX_LETTERS];
    int         lex_len  [LEX_SLOTS];
    int         lex_fill = 0;

    function automatic void clear_trie_model();
        int n;
        for (n = 0; n < NODES*ALPHA; n++) kid_ptr[n] = '0;
        for (n = 0; n < NODES; n++) pass_cnt[n] = '0;
        next_free  = 1;          // node 0 is the root
        walk_node  = 0;
        walk_depth = 0;
        hit_depth  = 0;
        hit_seen   = 1'b0;
        word_fault = ST_UNIQUE;
    endfunction

    // Advance the shadow trie by one letter; on a last letter queue the answer.
    function automatic void walk_trie(in_t w);
        int   slot;
        int   nxt;
        out_t ans;
        if (walk_depth < MAX_LEN) walk_depth++;
        if (word_fault == ST_UNIQUE) begin
            if (w.letter >= ALPHA) begin
                word_fault = ST_ABSENT;              // bad letter poisons the word
            end else if (w.func == FUNC_INSERT) begin
                slot = walk_node * ALPHA + w.letter;
                nxt  = kid_ptr[slot];
                if (nxt == 0 && next_free >= NODES) begin
                    word_fault = ST_FULL;            // counts raised so far stay raised
                end else begin
                    if (nxt == 0) begin
                        nxt = next_free;
                        next_free++;
                        kid_ptr[slot] = 10'(nxt);
                    end
                    walk_node = nxt;
                    if (pass_cnt[nxt] != COUNT_MAX) pass_cnt[nxt]++;
                end
            end else if (!hit_seen) begin
                // once the unique node is found, later query letters do nothing
                nxt = kid_ptr[walk_node * ALPHA + w.letter];
                if (nxt == 0) begin
                    word_fault = ST_ABSENT;
                end else begin
                    walk_node = nxt;
                    if (pass_cnt[nxt] == 1) begin
                        hit_seen  = 1'b1;
                        hit_depth = walk_depth;
                    end
                end
            end
        end
        if (w.last_letter) begin
            // the form of the answer follows the selector of the last letter
            ans.prefix_length = '0;
            if (word_fault != ST_UNIQUE) begin
                ans.status = word_fault;
            end else if (w.func == FUNC_INSERT) begin
                ans.status = ST_UNIQUE;
            end else if (hit_seen) begin
                ans.status        = ST_UNIQUE;
                ans.prefix_length = LEN_W'(hit_depth);
            end else begin
                ans.status        = ST_WHOLE;
                ans.prefix_length = LEN_W'(walk_depth);
            end
            pending_answers.insert(pending_answers.size(), ans);
            walk_node  = 0;
            walk_depth = 0;
            hit_depth  = 0;
            hit_seen   = 1'b0;
            word_fault = ST_UNIQUE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: receiver readiness and the answer check.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic log_mismatch(string note);
        if (mismatch_count < 100) $display("MISMATCH @%0t: %s", $realtime, note);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : answer_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                log_mismatch($sformatf("unexpected result len=%0d status=%0d",
                                       m_data.prefix_length, m_data.status));
            end else begin
                want = pending_answers.pop_front();
                if (m_data.prefix_length !== want.prefix_length)
                    log_mismatch($sformatf("prefix_length %0d, want %0d",
                                           m_data.prefix_length, want.prefix_length));
                if (m_data.status !== want.status)
                    log_mismatch($sformatf("status %0d, want %0d",
                                           m_data.status, want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------
    // One word over the input channel. Valid stays up between back-to-back words;
    // it only drops in a step where no new word is offered.
    task automatic send_letter(in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (word_fault == ST_UNIQUE) letters_used++;
        walk_trie(w);
    endtask

    task automatic send_word();
        in_t w;
        int  n;
        for (n = 0; n < word_len; n++) begin
            w.func        = func_buf[n];
            w.letter      = word_buf[n];
            w.last_letter = (n == word_len - 1);
            send_letter(w);
        end
    endtask

    // Text form for directed words: 'a'..'z' are letters, '{' '|' '}' '~' are codes 26..29.
    task automatic put_word(string text, logic fn);
        int n;
        word_len = text.len();
        for (n = 0; n < word_len; n++) begin
            word_buf[n] = 5'(text[n] - 8'd97);
            func_buf[n] = fn;
        end
        send_word();
    endtask

    // Sender pause: nothing offered until every answer is back, then a latency margin.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [4:0] pick_letter();
        // mostly a tiny alphabet so paths share prefixes and go deep
        if ($urandom_range(99) < 85) return 5'($urandom_range(3));
        return 5'($urandom_range(ALPHA - 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_trie();
        put_word("a", FUNC_QUERY);       // nothing inserted yet: absent
        put_word("zy", FUNC_QUERY);
        settle();
    endtask

    task automatic test_prefix_basics();
        put_word("ab", FUNC_INSERT);
        put_word("ac", FUNC_INSERT);
        put_word("b", FUNC_INSERT);
        put_word("ab", FUNC_QUERY);      // unique at depth 2
        put_word("a", FUNC_QUERY);       // shared node only: whole word
        put_word("abzz", FUNC_QUERY);    // letters after the unique node are skipped
        put_word("ad", FUNC_QUERY);      // missing child
        put_word("b", FUNC_QUERY);
        put_word("ab", FUNC_INSERT);
        put_word("ab", FUNC_QUERY);      // now shared all the way down
        settle();
    endtask

    task automatic test_bad_letters();
        put_word("c{", FUNC_INSERT);     // code 26 ends the insert early
        put_word("|a", FUNC_QUERY);
        word_len = 3;
        word_buf[0] = 5'd2;
        word_buf[1] = 5'd31;             // all letter bits set
        word_buf[2] = 5'd3;
        func_buf[0] = FUNC_INSERT;
        func_buf[1] = FUNC_INSERT;
        func_buf[2] = FUNC_INSERT;
        send_word();
        put_word("c", FUNC_QUERY);
        put_word("c~", FUNC_QUERY);      // bad letter as the final letter of a query
        put_word("}", FUNC_INSERT);
        settle();
    endtask

    task automatic test_mixed_selector();
        put_word("ef", FUNC_INSERT);
        func_buf[1] = FUNC_QUERY;        // insert e, then query f below it
        send_word();
        put_word("ab", FUNC_QUERY);
        func_buf[1] = FUNC_INSERT;       // query a, insert b: answer takes insert form
        send_word();
        put_word("eg", FUNC_QUERY);
        func_buf[1] = FUNC_INSERT;       // query e, shared so no unique hit, then insert g below it
        send_word();
        put_word("egh", FUNC_INSERT);
        func_buf[2] = FUNC_QUERY;
        send_word();
        settle();
    endtask

    // Words longer than the depth limit: the whole-word length stops at MAX_LEN.
    task automatic test_depth_saturation();
        int n;
        int pass;
        for (pass = 0; pass < 3; pass++) begin
            word_len = MAX_LEN + 2;
            for (n = 0; n < word_len; n++) begin
                word_buf[n] = 5'((n * 7 + 3) % ALPHA);
                func_buf[n] = (pass == 2) ? FUNC_QUERY : FUNC_INSERT;
            end
            send_word();
        end
        word_len = MAX_LEN + 3;          // one step past the stored path
        word_buf[word_len-1] = 5'd0;
        func_buf[word_len-1] = FUNC_QUERY;
        send_word();
        settle();
    endtask

    // Receiver refuses results for a long stretch while single-letter words keep coming.
    task automatic test_output_stall();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 30;
        hold_left <= 300;
        for (n = 0; n < 40; n++) begin
            word_len    = 1;
            word_buf[0] = 5'(n % 5);
            func_buf[0] = (n % 3 == 0) ? FUNC_INSERT : FUNC_QUERY;
            send_word();
        end
        settle();
    endtask

    task automatic test_random_words();
        int   phase;
        int   target;
        int   pick;
        int   n;
        int   slot;
        logic fn;
        bit   clean;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = letters_used + RANDOM_LETTERS / 3;
            while (letters_used < target) begin
                if ($urandom_range(99) < 55 && lex_fill > 0) begin
                    // reuse a known word, sometimes cut short or grown
                    pick     = $urandom_range(lex_fill - 1);
                    word_len = lex_len[pick];
                    for (n = 0; n < word_len; n++) word_buf[n] = lex_word[pick][n];
                    if ($urandom_range(99) < 30) word_len = $urandom_range(1, word_len);
                    if ($urandom_range(99) < 20) begin
                        repeat ($urandom_range(1, 2)) begin
                            word_buf[word_len] = pick_letter();
                            word_len++;
                        end
                    end
                end else begin
                    word_len = $urandom_range(1, 8);
                    for (n = 0; n < word_len; n++) word_buf[n] = pick_letter();
                end
                fn    = 1'($urandom_range(1));
                clean = 1'b1;
                for (n = 0; n < word_len; n++) func_buf[n] = fn;
                if ($urandom_range(99) < 6) begin
                    clean = 1'b0;
                    word_buf[$urandom_range(word_len - 1)] =
                        ($urandom_range(1) != 0) ? 5'($urandom_range(26, 31))
                                                 : 5'($urandom_range(31));
                end
                if ($urandom_range(99) < 6) begin
                    clean = 1'b0;
                    for (n = 0; n < word_len; n++) func_buf[n] = 1'($urandom_range(1));
                end
                if (clean && fn == FUNC_INSERT && word_len <= 10) begin
                    if (lex_fill < LEX_SLOTS) begin
                        slot = lex_fill;
                        lex_fill++;
                    end else begin
                        slot = $urandom_range(LEX_SLOTS - 1);
                    end
                    lex_len[slot] = word_len;
                    for (n = 0; n < word_len; n++) lex_word[slot][n] = word_buf[n];
                end
                send_word();
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_trie_model();
        send_idle_pct = 30;
        recv_idle_pct = 53;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // the first word simply waits out the child table clearing sweep
        test_empty_trie();
        test_prefix_basics();
        test_bad_letters();
        test_mixed_selector();
        test_depth_saturation();
        test_output_stall();
        test_random_words();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run (clearing sweep plus a few hundred words).
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
